/* rtl/cls_pkg.sv */
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and constants for the colour life step core: packed cell
// layout, neighbourhood window, judge request and result records.
// ----------------------------------------------------------------------------
package cls_pkg;

    // field widths fixed by the cell stream format
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned CNT_W   = 4;   // live neighbour count, 0..8
    localparam int unsigned SUM_W   = 11;  // sum of up to 8 colour components

    // life rule thresholds
    localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;

    // reciprocal of three, exact floor for sums below 2048
    localparam int unsigned      RECIP_W     = 10;
    localparam logic [RECIP_W-1:0] RECIP_THIRD = 10'd683;
    localparam int unsigned      RECIP_SHIFT = 11;

    // one grid cell
    typedef struct packed {
        logic               alive;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_cell;

    // one line store entry: the two rows above the current one
    typedef struct packed {
        t_cell upper;
        t_cell middle;
    } t_line_pair;

    // 3x3 window, entry index is row * 3 + column (row 0 oldest, column 0 oldest)
    typedef t_cell [8:0] t_window;

    // one cell to judge, taken from the window
    typedef struct packed {
        t_window          win;
        logic [2:0]       row_ok;   // window row lies inside the grid
        logic [2:0]       col_ok;   // window column lies inside the grid
        logic             lower;    // centre on window row 2, else row 1
        logic             right;    // centre on window column 2, else column 1
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } t_judge_req;

    // one emitted cell
    typedef struct packed {
        logic               next_alive;
        logic [COLOR_W-1:0] next_red;
        logic [COLOR_W-1:0] next_green;
        logic [COLOR_W-1:0] next_blue;
        logic [POS_W-1:0]   out_column;
        logic [POS_W-1:0]   out_row;
        logic               frame_done;
    } t_result;

endpackage

/* rtl/color_life_automaton_step_core.sv */
// Path: when its window completes (one row plus one cell on), a cell's result passes line store
// read, window register, neighbour gather and output register. Throughput: one request per
// cycle while o_stall is low; the single judge takes cells in turn, so requests that complete
// two cells (last column below row 0, last row past column 0) or four (frame end) stall input.
// Reset (synchronous, active low) clears handshake state and the raster position; the line
// store is not cleared, entries outside the grid are masked by position.
// ----------------------------------------------------------------------------
// color_life_automaton_step_core
// Colour life step, rule B3/S23, over a raster stream of cells with a line
// store memory, a 3x3 window and a shared judge unit.
// ----------------------------------------------------------------------------
module color_life_automaton_step_core #(
    parameter int unsigned GRID_COLUMNS = 32,
    parameter int unsigned GRID_ROWS    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_alive,
    input  logic [cls_pkg::COLOR_W-1:0]     i_red,
    input  logic [cls_pkg::COLOR_W-1:0]     i_green,
    input  logic [cls_pkg::COLOR_W-1:0]     i_blue,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_next_alive,
    output logic [cls_pkg::COLOR_W-1:0]     o_next_red,
    output logic [cls_pkg::COLOR_W-1:0]     o_next_green,
    output logic [cls_pkg::COLOR_W-1:0]     o_next_blue,
    output logic [cls_pkg::POS_W-1:0]       o_out_column,
    output logic [cls_pkg::POS_W-1:0]       o_out_row,
    output logic                            o_frame_done
);
    import cls_pkg::*;

    localparam int unsigned ADDR_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;

    // raster position of the next request
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;

    // request waiting for its line store read
    logic             r_s1_vld;
    t_cell            r_s1_cell;
    logic [POS_W-1:0] r_s1_col;
    logic [POS_W-1:0] r_s1_row;

    logic             in_acc, s1_adv, win_free;
    t_line_pair       rd_data, wr_data;
    t_cell [2:0]      fresh;
    logic             req_valid, req_ready;
    t_judge_req       req;
    t_result          res;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = r_s1_vld && !win_free;
    assign s1_adv  = r_s1_vld && win_free;

    // position counters
    always_comb begin
        if (r_col == POS_W'(GRID_COLUMNS - 1)) begin
            n_col = '0;
            n_row = (r_row == POS_W'(GRID_ROWS - 1)) ? '0 : r_row + POS_W'(1);
        end else begin
            n_col = r_col + POS_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cell <= '{alive: i_alive, red: i_red, green: i_green, blue: i_blue};
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
        end
    end

    // line store rotation: middle row moves up, new cell becomes middle
    always_comb begin
        wr_data.upper  = rd_data.middle;
        wr_data.middle = r_s1_cell;
        fresh[0]       = rd_data.upper;
        fresh[1]       = rd_data.middle;
        fresh[2]       = r_s1_cell;
    end

    cls_line_mem #(
        .DEPTH  (GRID_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col[ADDR_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col[ADDR_W-1:0]),
        .i_wr_data (wr_data)
    );

    cls_window #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (s1_adv),
        .i_fresh     (fresh),
        .i_row       (r_s1_row),
        .i_col       (r_s1_col),
        .o_free      (win_free),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    cls_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_valid     (o_valid),
        .o_result    (res),
        .i_stall     (i_stall)
    );

    // result fields
    assign o_next_alive = res.next_alive;
    assign o_next_red   = res.next_red;
    assign o_next_green = res.next_green;
    assign o_next_blue  = res.next_blue;
    assign o_out_column = res.out_column;
    assign o_out_row    = res.out_row;
    assign o_frame_done = res.frame_done;

endmodule

/* rtl/cls_line_mem.sv */
// ----------------------------------------------------------------------------
// cls_line_mem
// Line store: one entry per column holding the cells of the two previous
// rows. One registered read port, one write port.
// ----------------------------------------------------------------------------
module cls_line_mem #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output cls_pkg::t_line_pair o_rd_data,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  cls_pkg::t_line_pair i_wr_data
);
    import cls_pkg::*;

    t_line_pair r_mem [DEPTH];
    t_line_pair r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/cls_window.sv */
// ----------------------------------------------------------------------------
// cls_window
// 3x3 neighbourhood window and result sequencer. Shifts in one column per
// request and hands the judge unit the zero to four cells that it completes.
// ----------------------------------------------------------------------------
module cls_window #(
    parameter int unsigned GRID_COLUMNS = 32,
    parameter int unsigned GRID_ROWS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  cls_pkg::t_cell [2:0]          i_fresh,
    input  logic [cls_pkg::POS_W-1:0]     i_row,
    input  logic [cls_pkg::POS_W-1:0]     i_col,
    output logic                          o_free,
    output logic                          o_req_valid,
    output cls_pkg::t_judge_req           o_req,
    input  logic                          i_req_ready
);
    import cls_pkg::*;

    t_window          r_win, n_win;
    logic [3:0]       r_pend;
    logic [2:0]       r_row_ok;
    logic [2:0]       r_col_ok;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic             r_frame_end;

    logic             row_ge1, col_ge1, last_row, last_col;
    logic [3:0]       new_pend;
    logic [1:0]       sel;
    logic [3:0]       sel_mask;
    logic             issue, single;

    // cells completed by the incoming column
    always_comb begin
        row_ge1  = (i_row != '0);
        col_ge1  = (i_col != '0);
        last_row = (i_row == POS_W'(GRID_ROWS - 1));
        last_col = (i_col == POS_W'(GRID_COLUMNS - 1));
        new_pend = {last_row & last_col, last_row & col_ge1,
                    row_ge1 & last_col,  row_ge1 & col_ge1};
    end

    // window shift, newest column on the right
    always_comb begin
        n_win = r_win;
        for (int a = 0; a < 3; a++) begin
            n_win[a*3]     = r_win[a*3 + 1];
            n_win[a*3 + 1] = r_win[a*3 + 2];
            n_win[a*3 + 2] = i_fresh[a];
        end
    end

    // pick the oldest pending cell
    always_comb begin
        if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else if (r_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        sel_mask = 4'b0001 << sel;
        single   = ((r_pend & (r_pend - 4'd1)) == 4'd0);
        issue    = (r_pend != 4'd0) && i_req_ready;
        o_free   = (r_pend == 4'd0) || (issue && single);
    end

    // request to the judge unit
    always_comb begin
        o_req_valid  = (r_pend != 4'd0);
        o_req.win    = r_win;
        o_req.row_ok = r_row_ok;
        o_req.col_ok = r_col_ok;
        o_req.lower  = sel[1];
        o_req.right  = sel[0];
        o_req.row    = sel[1] ? r_row : r_row - POS_W'(1);
        o_req.col    = sel[0] ? r_col : r_col - POS_W'(1);
        o_req.done   = r_frame_end && single;
    end

    // pending list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 4'd0;
        end else if (i_shift) begin
            r_pend <= new_pend;
        end else if (issue) begin
            r_pend <= r_pend & ~sel_mask;
        end
    end

    // window and its position
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win       <= n_win;
            r_row       <= i_row;
            r_col       <= i_col;
            r_row_ok    <= {1'b1, row_ge1, i_row > POS_W'(1)};
            r_col_ok    <= {1'b1, col_ge1, i_col > POS_W'(1)};
            r_frame_end <= last_row & last_col;
        end
    end

endmodule

/* rtl/cls_judge.sv */
// ----------------------------------------------------------------------------
// cls_judge
// Shared judge unit: gathers live neighbours of one cell per cycle unless
// stalled; B3/S23 and the colour average follow in the output register stage.
// ----------------------------------------------------------------------------
module cls_judge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  cls_pkg::t_judge_req i_req,
    output logic                o_req_ready,
    output logic                o_valid,
    output cls_pkg::t_result    o_result,
    input  logic                i_stall
);
    import cls_pkg::*;

    // gather stage registers
    logic             r_a_vld;
    logic [CNT_W-1:0] r_a_cnt;
    logic [SUM_W-1:0] r_a_sum_r, r_a_sum_g, r_a_sum_b;
    logic             r_a_self;
    logic [POS_W-1:0] r_a_row, r_a_col;
    logic             r_a_done;

    // output stage registers
    logic             r_o_vld;
    t_result          r_res, n_res;

    logic             b_ready, a_load;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum_r, sum_g, sum_b;
    logic             self_alive;
    logic [2:0]       row_near, col_near;
    logic             take, born, three;

    // truncated average by two or three
    function automatic logic [COLOR_W-1:0] avg(input logic [SUM_W-1:0] sum,
                                               input logic by_three);
        logic [SUM_W+RECIP_W-1:0] prod;
        begin
            prod = (SUM_W + RECIP_W)'(sum) * (SUM_W + RECIP_W)'(RECIP_THIRD);
            avg  = by_three ? prod[RECIP_SHIFT +: COLOR_W] : sum[1 +: COLOR_W];
        end
    endfunction

    assign b_ready     = !r_o_vld || !i_stall;
    assign o_req_ready = !r_a_vld || b_ready;
    assign a_load      = i_req_valid && o_req_ready;

    // neighbour gather over the window
    always_comb begin
        row_near = {1'b1, 1'b1, !i_req.lower};
        col_near = {1'b1, 1'b1, !i_req.right};
        cnt      = '0;
        sum_r    = '0;
        sum_g    = '0;
        sum_b    = '0;
        take     = 1'b0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                take = row_near[a] && col_near[b] && i_req.row_ok[a] && i_req.col_ok[b]
                       && !((a == (i_req.lower ? 2 : 1)) && (b == (i_req.right ? 2 : 1)))
                       && i_req.win[a*3 + b].alive;
                cnt   = cnt + CNT_W'(take);
                sum_r = sum_r + (take ? SUM_W'(i_req.win[a*3 + b].red)   : '0);
                sum_g = sum_g + (take ? SUM_W'(i_req.win[a*3 + b].green) : '0);
                sum_b = sum_b + (take ? SUM_W'(i_req.win[a*3 + b].blue)  : '0);
            end
        end
        case ({i_req.lower, i_req.right})
            2'b00:   self_alive = i_req.win[4].alive;
            2'b01:   self_alive = i_req.win[5].alive;
            2'b10:   self_alive = i_req.win[7].alive;
            2'b11:   self_alive = i_req.win[8].alive;
            default: self_alive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (o_req_ready) begin
            r_a_vld <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_cnt   <= cnt;
            r_a_sum_r <= sum_r;
            r_a_sum_g <= sum_g;
            r_a_sum_b <= sum_b;
            r_a_self  <= self_alive;
            r_a_row   <= i_req.row;
            r_a_col   <= i_req.col;
            r_a_done  <= i_req.done;
        end
    end

    // life rule and colour average
    always_comb begin
        three = (r_a_cnt == BIRTH_COUNT);
        born  = three || (r_a_self && (r_a_cnt == SURVIVE_COUNT));
        n_res.next_alive = born;
        n_res.next_red   = born ? avg(r_a_sum_r, three) : '0;
        n_res.next_green = born ? avg(r_a_sum_g, three) : '0;
        n_res.next_blue  = born ? avg(r_a_sum_b, three) : '0;
        n_res.out_column = r_a_col;
        n_res.out_row    = r_a_row;
        n_res.frame_done = r_a_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_ready) begin
            r_o_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_vld) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_result = r_res;

endmodule

/* tb/sv/color_life_automaton_step_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_life_automaton_step_core_test
// Streams the first ten rows of a 32x32 generation through the colour life
// step core under random idling on both sides. Every accepted cell request
// feeds a local B3/S23 predictor that keeps its own line stores and 3x3
// window. Each emitted cell is checked field by field against the oldest
// predicted cell.
// ----------------------------------------------------------------------------
module color_life_automaton_step_core_test;

    import cls_pkg::*;

    localparam int COLS            = 32;
    localparam int ROWS            = 32;
    localparam int BIRTH_NEIGH     = 3;
    localparam int SURVIVE_NEIGH   = 2;
    localparam int DRAIN_AT        = 200;   // sender pause point
    localparam int HOLD_AT         = 60;    // receiver hold-off point
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTS      = 100;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SATURATED} t_fill;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // block inputs, known from the start
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic               i_alive = 1'b0;
    logic [COLOR_W-1:0] i_red   = '0;
    logic [COLOR_W-1:0] i_green = '0;
    logic [COLOR_W-1:0] i_blue  = '0;

    // block outputs
    logic               o_stall;
    logic               o_valid;
    logic               o_next_alive;
    logic [COLOR_W-1:0] o_next_red;
    logic [COLOR_W-1:0] o_next_green;
    logic [COLOR_W-1:0] o_next_blue;
    logic [POS_W-1:0]   o_out_column;
    logic [POS_W-1:0]   o_out_row;
    logic               o_frame_done;

    // cell requests still to send, predicted cells still to arrive
    t_cell   raster_cells[$];
    t_result next_gen_cells[$];

    // predictor state
    t_cell upper_line  [COLS];
    t_cell middle_line [COLS];
    t_cell win [3][3];
    int    pos_col;
    int    pos_row;

    // driver and monitor bookkeeping
    int sent_count  = 0;
    int send_gap    = 0;
    bit send_quiet  = 1'b0;
    bit draining    = 1'b0;
    int got_count   = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int rx_cycles   = 0;
    bit rx_quiet    = 1'b0;
    int mismatches  = 0;
    int idle_cycles = 0;

    color_life_automaton_step_core #(
        .GRID_COLUMNS (COLS),
        .GRID_ROWS    (ROWS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_alive      (i_alive),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_next_alive (o_next_alive),
        .o_next_red   (o_next_red),
        .o_next_green (o_next_green),
        .o_next_blue  (o_next_blue),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_frame_done (o_frame_done)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none during a quiet stretch
    function automatic int pick_gap(bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // colour levels at the edges and the middle of the byte
    function automatic logic [COLOR_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'h80;
            4: return 8'h7F;
            default: return 8'hFE;
        endcase
    endfunction

    // a run of cell requests in raster order
    task automatic fill_frame(input int count, input int density, input t_fill fill);
        t_cell px;
        for (int k = 0; k < count; k++) begin
            px.alive = ($urandom_range(0, 99) < density);
            case (fill)
                FILL_SATURATED: begin
                    px = '1;
                end
                FILL_EXTREME: begin
                    px.red   = pick_extreme();
                    px.green = pick_extreme();
                    px.blue  = pick_extreme();
                end
                default: begin
                    px.red   = COLOR_W'($urandom_range(0, 255));
                    px.green = COLOR_W'($urandom_range(0, 255));
                    px.blue  = COLOR_W'($urandom_range(0, 255));
                end
            endcase
            raster_cells.push_back(px);
        end
    endtask

    // next generation of the cell at window slot (wa, wb), grid position (row, col)
    function automatic t_result next_state_of(int wa, int wb, int row, int col);
        t_result res;
        t_cell   nb;
        int      cnt, sr, sg, sb, nr, nc, a, b;
        bit      lives;
        cnt = 0;
        sr  = 0;
        sg  = 0;
        sb  = 0;
        for (int da = -1; da <= 1; da++) begin
            for (int db = -1; db <= 1; db++) begin
                nr = row + da;
                nc = col + db;
                a  = wa + da;
                b  = wb + db;
                // neighbours off the grid or outside the window never count
                if (!(da == 0 && db == 0) && nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS
                        && a >= 0 && a <= 2 && b >= 0 && b <= 2) begin
                    nb = win[a][b];
                    if (nb.alive) begin
                        cnt++;
                        sr += nb.red;
                        sg += nb.green;
                        sb += nb.blue;
                    end
                end
            end
        end
        if (win[wa][wb].alive)
            lives = (cnt == SURVIVE_NEIGH || cnt == BIRTH_NEIGH);
        else
            lives = (cnt == BIRTH_NEIGH);
        res = '0;
        if (lives) begin
            res.next_alive = 1'b1;
            res.next_red   = COLOR_W'(sr / cnt);
            res.next_green = COLOR_W'(sg / cnt);
            res.next_blue  = COLOR_W'(sb / cnt);
        end
        res.out_column = POS_W'(col);
        res.out_row    = POS_W'(row);
        return res;
    endfunction

    // advance the raster by one cell and queue the cells it completes
    task automatic step_life_raster(input t_cell cur);
        t_cell   fresh [3];
        t_result res;
        bit      last_row, last_col;
        fresh[0] = upper_line[pos_col];
        fresh[1] = middle_line[pos_col];
        fresh[2] = cur;
        upper_line[pos_col]  = middle_line[pos_col];
        middle_line[pos_col] = cur;
        for (int a = 0; a < 3; a++) begin
            win[a][0] = win[a][1];
            win[a][1] = win[a][2];
            win[a][2] = fresh[a];
        end
        last_row = (pos_row == ROWS - 1);
        last_col = (pos_col == COLS - 1);
        // row above: the cell one behind, plus the row end
        if (pos_row >= 1) begin
            if (pos_col >= 1) next_gen_cells.push_back(next_state_of(1, 1, pos_row - 1, pos_col - 1));
            if (last_col) next_gen_cells.push_back(next_state_of(1, 2, pos_row - 1, pos_col));
        end
        // last row flushes itself, the very last cell closes the generation
        if (last_row) begin
            if (pos_col >= 1) next_gen_cells.push_back(next_state_of(2, 1, pos_row, pos_col - 1));
            if (last_col) begin
                res = next_state_of(2, 2, pos_row, pos_col);
                res.frame_done = 1'b1;
                next_gen_cells.push_back(res);
            end
        end
        if (last_col) begin
            pos_col = 0;
            pos_row = last_row ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input t_result ref_cell);
        if (got !== want)
            report_mismatch($sformatf("%s at row %0d col %0d: got %0d, want %0d", name,
                                      ref_cell.out_row, ref_cell.out_column, got, want));
    endtask

    // driver: presents the head request, holds it while stalled
    always @(posedge i_clk) begin : driver
        bit    offer;
        t_cell head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offer = i_valid;
            if (i_valid && !o_stall) begin
                head = raster_cells.pop_front();
                step_life_raster(head);
                sent_count++;
                offer = 1'b0;
                send_gap = pick_gap(send_quiet);
                if (sent_count % COLS == 0) send_quiet = ($urandom_range(0, 3) == 0);
                if (sent_count == DRAIN_AT) draining = 1'b1;
            end
            if (!offer) begin
                if (draining) begin
                    if (next_gen_cells.size() == 0) draining = 1'b0;
                end else if (send_gap > 0) begin
                    send_gap--;
                end else if (raster_cells.size() != 0) begin
                    offer = 1'b1;
                    i_alive <= raster_cells[0].alive;
                    i_red   <= raster_cells[0].red;
                    i_green <= raster_cells[0].green;
                    i_blue  <= raster_cells[0].blue;
                end
            end
            i_valid <= offer;
        end
    end

    // monitor: checks each accepted cell and drives the receiver stall
    always @(posedge i_clk) begin : monitor
        t_result got, want;
        bit      hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.next_alive = o_next_alive;
                got.next_red   = o_next_red;
                got.next_green = o_next_green;
                got.next_blue  = o_next_blue;
                got.out_column = o_out_column;
                got.out_row    = o_out_row;
                got.frame_done = o_frame_done;
                if (next_gen_cells.size() == 0) begin
                    report_mismatch($sformatf("cell at row %0d col %0d with nothing expected",
                                              got.out_row, got.out_column));
                end else begin
                    want = next_gen_cells.pop_front();
                    check_field("next_alive", got.next_alive, want.next_alive, want);
                    check_field("next_red",   got.next_red,   want.next_red,   want);
                    check_field("next_green", got.next_green, want.next_green, want);
                    check_field("next_blue",  got.next_blue,  want.next_blue,  want);
                    check_field("out_column", got.out_column, want.out_column, want);
                    check_field("out_row",    got.out_row,    want.out_row,    want);
                    check_field("frame_done", got.frame_done, want.frame_done, want);
                end
                got_count++;
            end
            rx_cycles++;
            if (rx_cycles % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            // one long hold-off so the block backs up into its input
            if (!hold_done && got_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                hold = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                hold = 1'b1;
            end else begin
                stall_left = pick_gap(rx_quiet);
                hold = (stall_left > 0);
                if (hold) stall_left--;
            end
            i_stall <= hold;
        end
    end

    // watchdog on cycles with no request or result moving
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus and end of run
    initial begin : stimulus
        for (int k = 0; k < COLS; k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = '0;
        pos_col = 0;
        pos_row = 0;

        // two rows all live at full colour, crowded except at the row ends
        fill_frame(2 * COLS, 100, FILL_SATURATED);
        // edge colour levels, moderate density
        fill_frame(2 * COLS, 35, FILL_EXTREME);
        // random colours at mixed densities
        fill_frame(2 * COLS, 45, FILL_RANDOM);
        fill_frame(2 * COLS, 10, FILL_RANDOM);
        fill_frame(2 * COLS, 60, FILL_RANDOM);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (raster_cells.size() != 0) @(posedge i_clk);
        while (next_gen_cells.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
